@@ hdl/sec_pkg.sv @@
// shared types and constants of the sprite entry column expander
package sec_pkg;

  // screen row that raw y and the column height are subtracted from
  localparam logic [9:0] Y_ORIGIN = 10'd384;

  // log2 of the tile height in pixels
  localparam int TILE_SHIFT = 4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;     // take a new entry, restart at the top row
    logic advance;  // current tile beat delivered, step to the next row
  } sec_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;     // current row is the bottom tile of the column
  } sec_status_t;

endpackage

@@ hdl/sprite_entry_column_expand.sv @@
// top level of the sprite entry column expander
//
// Takes one sprite attribute entry per input beat (seven bytes, byte 1 left
// out) and produces one draw command per 16-pixel tile of the sprite's
// column, top row first, 1, 2, 4 or 8 beats per entry. The last beat of an
// entry has out_final_tile set.
// Both channels use valid/ready; a beat moves when both are high.
// Latency: the first tile beat is valid the cycle after the entry is taken.
// Only one entry is held at a time; the single row counter steps one tile per
// delivered output beat, and the next entry can be taken in the cycle after the
// final beat is delivered.
// When the receiver holds out_ready low, the current beat and its row hold
// and in_ready stays low until the column is finished.
// Synchronous reset (rst_n low) returns to idle with in_ready high and
// out_valid low; any column in progress is dropped.
module sprite_entry_column_expand
  import sec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_color_byte,
  input  logic [7:0]  in_ypos_low,
  input  logic [7:0]  in_ypos_high,
  input  logic [7:0]  in_code_low,
  input  logic [7:0]  in_attr_byte,
  input  logic [7:0]  in_xpos_low,
  input  logic [7:0]  in_xpos_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_tile_code,
  output logic [3:0]  out_palette_sel,
  output logic        out_mirror_x,
  output logic        out_mirror_y,
  output logic [8:0]  out_screen_x,
  output logic signed [9:0] out_screen_y,
  output logic        out_final_tile
);

  sec_cmd_t    cmd;
  sec_status_t status;

  // sequencing
  sec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // decode and tile fields
  sec_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .color_byte  (in_color_byte),
    .ypos_low    (in_ypos_low),
    .ypos_high   (in_ypos_high),
    .code_low    (in_code_low),
    .attr_byte   (in_attr_byte),
    .xpos_low    (in_xpos_low),
    .xpos_high   (in_xpos_high),
    .tile_code   (out_tile_code),
    .palette_sel (out_palette_sel),
    .mirror_x    (out_mirror_x),
    .mirror_y    (out_mirror_y),
    .screen_x    (out_screen_x),
    .screen_y    (out_screen_y),
    .final_tile  (out_final_tile)
  );

endmodule

@@ hdl/sec_ctrl.sv @@
// controller: sequences one entry at a time through its tile beats
module sec_ctrl
  import sec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output sec_cmd_t    cmd,
  input  sec_status_t status
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  // handshakes turned into datapath commands
  assign cmd.load    = in_valid & in_ready_r;
  assign cmd.advance = out_valid_r & out_ready;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  // next state and registered handshake outputs
  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt     = ST_EMIT;
          in_ready_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        if (cmd.advance && status.last) begin
          state_nxt     = ST_IDLE;
          in_ready_nxt  = 1'b1;
          out_valid_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        in_ready_nxt  = 1'b1;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/sec_dp.sv @@
// datapath: entry decode, column registers and per-row tile fields
module sec_dp
  import sec_pkg::*;
(
  input  logic        clk,
  input  sec_cmd_t    cmd,
  output sec_status_t status,
  input  logic [7:0]  color_byte,
  input  logic [7:0]  ypos_low,
  input  logic [7:0]  ypos_high,
  input  logic [7:0]  code_low,
  input  logic [7:0]  attr_byte,
  input  logic [7:0]  xpos_low,
  input  logic [7:0]  xpos_high,
  output logic [11:0] tile_code,
  output logic [3:0]  palette_sel,
  output logic        mirror_x,
  output logic        mirror_y,
  output logic [8:0]  screen_x,
  output logic signed [9:0] screen_y,
  output logic        final_tile
);

  logic [1:0]  height_log2;
  logic [3:0]  height;
  logic [2:0]  height_m1;
  logic [8:0]  raw_y;
  logic [11:0] base_code;
  logic [9:0]  top_y;

  logic [11:0] code_r;
  logic [3:0]  color_r;
  logic        fx_r;
  logic        fy_r;
  logic [8:0]  sx_r;
  logic [2:0]  hm1_r;
  logic [2:0]  row_r, row_nxt;
  logic [9:0]  y_r, y_nxt;
  logic [2:0]  off;

  // entry decode
  assign height_log2 = attr_byte[5:4];
  assign height      = 4'd1 << height_log2;
  assign height_m1   = 3'(height - 4'd1);
  assign raw_y       = {ypos_high[0], ypos_low};
  assign base_code   = {attr_byte[3:0], code_low} & ~{9'd0, height_m1};
  // column top, wrapping in ten bits
  assign top_y       = Y_ORIGIN - {1'b0, raw_y} - ({6'd0, height} << TILE_SHIFT);

  // row counter and running y
  always_comb begin
    row_nxt = row_r;
    y_nxt   = y_r;
    if (cmd.load) begin
      row_nxt = 3'd0;
      y_nxt   = top_y;
    end else if (cmd.advance) begin
      row_nxt = row_r + 3'd1;
      y_nxt   = y_r + (10'd1 << TILE_SHIFT);
    end
  end

  // per-entry fields held for the whole column, plus the row counter and running y
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r  <= base_code;
      color_r <= color_byte[3:0];
      fx_r    <= attr_byte[6];
      fy_r    <= attr_byte[7];
      sx_r    <= {xpos_high[0], xpos_low};
      hm1_r   <= height_m1;
    end
    row_r <= row_nxt;
    y_r   <= y_nxt;
  end

  // tile offset, counted from the bottom when mirrored in y
  assign off = fy_r ? (hm1_r - row_r) : row_r;

  assign status.last = (row_r == hm1_r);

  assign tile_code   = code_r | {9'd0, off};
  assign palette_sel = color_r;
  assign mirror_x    = fx_r;
  assign mirror_y    = fy_r;
  assign screen_x    = sx_r;
  assign screen_y    = y_r;
  assign final_tile  = status.last;

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the sprite entry column expander
module tb_top
  import sec_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_ROWS         = 15;
  localparam int RAND_ITEMS       = 400;
  localparam int LONG_HOLD_AT     = 1500;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES     = 16;

  // raw attribute entry, byte 1 left out
  typedef struct packed {
    logic [7:0] color_byte;
    logic [7:0] ypos_low;
    logic [7:0] ypos_high;
    logic [7:0] code_low;
    logic [7:0] attr_byte;
    logic [7:0] xpos_low;
    logic [7:0] xpos_high;
  } sprite_entry_t;

  // one draw command beat
  typedef struct packed {
    logic [11:0] tile_code;
    logic [3:0]  palette_sel;
    logic        mirror_x;
    logic        mirror_y;
    logic [8:0]  screen_x;
    logic [9:0]  screen_y;
    logic        final_tile;
  } tile_cmd_t;

  // directed row: entry plus a hand-written command for single-tile cases
  typedef struct packed {
    sprite_entry_t entry;
    logic          typed;
    tile_cmd_t     want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_color_byte = '0;
  logic [7:0]  in_ypos_low = '0;
  logic [7:0]  in_ypos_high = '0;
  logic [7:0]  in_code_low = '0;
  logic [7:0]  in_attr_byte = '0;
  logic [7:0]  in_xpos_low = '0;
  logic [7:0]  in_xpos_high = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_tile_code;
  logic [3:0]  out_palette_sel;
  logic        out_mirror_x;
  logic        out_mirror_y;
  logic [8:0]  out_screen_x;
  logic signed [9:0] out_screen_y;
  logic        out_final_tile;

  tile_cmd_t pending_tiles [$];
  dir_row_t  dir_table [DIR_ROWS];
  int        errors = 0;
  int        beats_checked = 0;
  int        entries_sent = 0;
  int        columns_by_height [4] = '{0, 0, 0, 0};
  bit        sender_calm = 1'b0;

  sprite_entry_column_expand uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_color_byte  (in_color_byte),
    .in_ypos_low    (in_ypos_low),
    .in_ypos_high   (in_ypos_high),
    .in_code_low    (in_code_low),
    .in_attr_byte   (in_attr_byte),
    .in_xpos_low    (in_xpos_low),
    .in_xpos_high   (in_xpos_high),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tile_code  (out_tile_code),
    .out_palette_sel(out_palette_sel),
    .out_mirror_x   (out_mirror_x),
    .out_mirror_y   (out_mirror_y),
    .out_screen_x   (out_screen_x),
    .out_screen_y   (out_screen_y),
    .out_final_tile (out_final_tile)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // idle length: none when calm, else mostly none, some short, a few long
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // expected tile commands of one column, top row first
  task automatic predict_column(input sprite_entry_t e);
    logic [3:0]  height;
    logic [3:0]  row;
    logic [3:0]  offs;
    logic [11:0] base_code;
    logic [8:0]  raw_y;
    logic [9:0]  top_y;
    tile_cmd_t   cmd;
    height    = 4'd1 << e.attr_byte[5:4];
    base_code = {e.attr_byte[3:0], e.code_low} & ~({8'd0, height} - 12'd1);
    raw_y     = {e.ypos_high[0], e.ypos_low};
    top_y     = Y_ORIGIN - {1'b0, raw_y} - ({6'd0, height} << TILE_SHIFT);
    for (int r = 0; r < height; r++) begin
      row  = r[3:0];
      offs = e.attr_byte[7] ? (height - 4'd1 - row) : row;
      cmd.tile_code   = base_code | {8'd0, offs};
      cmd.palette_sel = e.color_byte[3:0];
      cmd.mirror_x    = e.attr_byte[6];
      cmd.mirror_y    = e.attr_byte[7];
      cmd.screen_x    = {e.xpos_high[0], e.xpos_low};
      cmd.screen_y    = top_y + ({6'd0, row} << TILE_SHIFT);
      cmd.final_tile  = (row == height - 4'd1);
      pending_tiles.push_back(cmd);
    end
  endtask

  // random entry, with raw y pushed to its ends now and then
  function automatic sprite_entry_t random_entry();
    sprite_entry_t e;
    logic [63:0]   bits;
    int pick;
    bits = {$urandom, $urandom};
    e = bits[55:0];
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      e.ypos_low  = 8'hff;
      e.ypos_high = e.ypos_high | 8'h01;
    end else if (pick == 1) begin
      e.ypos_low  = 8'h00;
      e.ypos_high = e.ypos_high & 8'hfe;
    end
    return e;
  endfunction

  // offer one entry and wait for its input beat
  task automatic send_entry(input sprite_entry_t e, input bit typed, input tile_cmd_t want);
    int gap;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_color_byte <= e.color_byte;
    in_ypos_low   <= e.ypos_low;
    in_ypos_high  <= e.ypos_high;
    in_code_low   <= e.code_low;
    in_attr_byte  <= e.attr_byte;
    in_xpos_low   <= e.xpos_low;
    in_xpos_high  <= e.xpos_high;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) pending_tiles.push_back(want);
    else predict_column(e);
    entries_sent++;
    columns_by_height[e.attr_byte[5:4]]++;
  endtask

  // sender pauses until every tile beat has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
  endtask

  function automatic int field_diff(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // output side pacing, with one long hold-off
  initial begin : sink_pacing
    int stall_left;
    int cyc;
    bit calm;
    bit long_done;
    stall_left = 0;
    cyc        = 0;
    calm       = 1'b0;
    long_done  = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 128 == 0) calm = ($urandom_range(0, 2) == 0);
      if (!long_done && cyc == LONG_HOLD_AT) begin
        stall_left = LONG_HOLD_CYCLES;
        long_done  = 1'b1;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap(calm);
      end
    end
  end

  // compare each output beat with the oldest expected command
  always @(posedge clk) begin
    tile_cmd_t want;
    int bad;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tiles.size() == 0) begin
        $display("%0t: unexpected tile beat, code %0d y %0d", $time, out_tile_code,
                 out_screen_y);
        errors++;
      end else begin
        want = pending_tiles.pop_front();
        bad  = 0;
        bad += field_diff("tile_code", want.tile_code, out_tile_code);
        bad += field_diff("palette_sel", want.palette_sel, out_palette_sel);
        bad += field_diff("mirror_x", want.mirror_x, out_mirror_x);
        bad += field_diff("mirror_y", want.mirror_y, out_mirror_y);
        bad += field_diff("screen_x", want.screen_x, out_screen_x);
        bad += field_diff("screen_y", $signed(want.screen_y), out_screen_y);
        bad += field_diff("final_tile", want.final_tile, out_final_tile);
        if (bad != 0) errors++;
        beats_checked++;
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    tile_cmd_t none;
    none = '0;

    // single tiles with hand-read results, then taller and mirrored columns
    dir_table[0]  = '{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
                      '{12'h000, 4'h0, 1'b0, 1'b0, 9'h000, 10'd368, 1'b1}};
    // all bits high, height one: y = 384 - 511 - 16 = -143
    dir_table[1]  = '{'{8'hff, 8'hff, 8'hff, 8'hff, 8'hcf, 8'hff, 8'hff}, 1'b1,
                      '{12'hfff, 4'hf, 1'b1, 1'b1, 9'h1ff, 10'h371, 1'b1}};
    // ignored bits set, everything else zero
    dir_table[2]  = '{'{8'hf0, 8'h00, 8'hfe, 8'h00, 8'h00, 8'h00, 8'hfe}, 1'b1,
                      '{12'h000, 4'h0, 1'b0, 1'b0, 9'h000, 10'd368, 1'b1}};
    dir_table[3]  = '{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00}, 1'b1,
                      '{12'h000, 4'h0, 1'b1, 1'b0, 9'h000, 10'd368, 1'b1}};
    dir_table[4]  = '{'{8'h0a, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00}, 1'b1,
                      '{12'h000, 4'ha, 1'b0, 1'b1, 9'h000, 10'd368, 1'b1}};
    // full code with heights 2, 4, 8: low code bits cleared
    dir_table[5]  = '{'{8'h03, 8'h10, 8'h00, 8'hff, 8'h1f, 8'h20, 8'h00}, 1'b0, none};
    dir_table[6]  = '{'{8'h05, 8'h20, 8'h00, 8'hff, 8'h2f, 8'h40, 8'h00}, 1'b0, none};
    dir_table[7]  = '{'{8'h07, 8'h30, 8'h00, 8'hff, 8'h3f, 8'h80, 8'h00}, 1'b0, none};
    dir_table[8]  = '{'{8'h09, 8'h40, 8'h00, 8'hff, 8'hbf, 8'h00, 8'h01}, 1'b0, none};
    // lowest top row, raw y 511 and eight tiles
    dir_table[9]  = '{'{8'h0c, 8'hff, 8'h01, 8'h00, 8'h30, 8'hff, 8'h01}, 1'b0, none};
    dir_table[10] = '{'{8'h0e, 8'h00, 8'h00, 8'h55, 8'h7a, 8'h11, 8'h00}, 1'b0, none};
    dir_table[11] = '{'{8'h01, 8'h80, 8'h00, 8'h33, 8'h95, 8'hc0, 8'h00}, 1'b0, none};
    dir_table[12] = '{'{8'h02, 8'h7f, 8'h01, 8'ha7, 8'he6, 8'h01, 8'h01}, 1'b0, none};
    dir_table[13] = '{'{8'h5b, 8'h00, 8'h01, 8'h12, 8'h3c, 8'h99, 8'h00}, 1'b0, none};
    dir_table[14] = '{'{8'h00, 8'hff, 8'h00, 8'hff, 8'h20, 8'h00, 8'h00}, 1'b0, none};

    // reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_entry(dir_table[i].entry, dir_table[i].typed, dir_table[i].want);
    end
    wait_drained();

    // random part, in stretches picked calm or gappy at random, drained halfway
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) sender_calm = ($urandom_range(0, 2) == 0);
      if (i == RAND_ITEMS / 2) wait_drained();
      send_entry(random_entry(), 1'b0, none);
    end
    in_valid <= 1'b0;

    // drain
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d entries (%0d directed), %0d tile beats checked", entries_sent,
             DIR_ROWS, beats_checked);
    $display("columns of height 1/2/4/8: %0d/%0d/%0d/%0d", columns_by_height[0],
             columns_by_height[1], columns_by_height[2], columns_by_height[3]);
    if (errors == 0) begin
      $display("PASS sprite_entry_column_expand");
    end else begin
      $display("FAIL sprite_entry_column_expand");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("timeout with %0d tile beats outstanding", pending_tiles.size());
    $display("FAIL sprite_entry_column_expand");
    $finish;
  end

endmodule
